>>> rtl/cab_pkg.sv
package cab_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CfgSrcRed    = 3'd0,
    CfgSrcGreen  = 3'd1,
    CfgSrcBlue   = 3'd2,
    CfgSrcAlpha  = 3'd3,
    CfgClipLeft  = 3'd4,
    CfgClipTop   = 3'd5,
    CfgClipRight = 3'd6,
    CfgClipBot   = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned ChanW    = 8;
  localparam logic [ChanW-1:0] AlphaFull = 8'hff;

  // Register file contents seen by the datapath
  typedef struct packed {
    logic        [ChanW-1:0]  src_red;
    logic        [ChanW-1:0]  src_green;
    logic        [ChanW-1:0]  src_blue;
    logic        [ChanW-1:0]  src_alpha;
    logic signed [CoordW-1:0] clip_left;
    logic signed [CoordW-1:0] clip_top;
    logic signed [CoordW-1:0] clip_right;
    logic signed [CoordW-1:0] clip_bottom;
  } cfg_t;

  // Divide a product of two 8-bit values by 255 as ((x + 1) * 257) >> 16
  function automatic logic [ChanW-1:0] div255(input logic [15:0] x);
    logic [16:0] xp;
    logic [24:0] acc;
    xp  = {1'b0, x} + 17'd1;
    acc = {xp, 8'd0} + {8'd0, xp};
    return acc[23:16];
  endfunction

  // Keep r[7:5], g[7:5], b[7:6] of 8-bit channels
  function automatic logic [7:0] pack332(input logic [ChanW-1:0] r,
                                         input logic [ChanW-1:0] g,
                                         input logic [ChanW-1:0] b);
    return {r[7:5], g[7:5], b[7:6]};
  endfunction

endpackage

>>> rtl/cab_cfg.sv
module cab_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cab_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cab_pkg::CfgDataW-1:0]   cfg_data_i,
  output cab_pkg::cfg_t                  cfg_o
);

  cab_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write index and update one register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cab_pkg::cfg_idx_e'(cfg_idx_i))
        cab_pkg::CfgSrcRed:    cfg_d.src_red     = cfg_data_i[7:0];
        cab_pkg::CfgSrcGreen:  cfg_d.src_green   = cfg_data_i[7:0];
        cab_pkg::CfgSrcBlue:   cfg_d.src_blue    = cfg_data_i[7:0];
        cab_pkg::CfgSrcAlpha:  cfg_d.src_alpha   = cfg_data_i[7:0];
        cab_pkg::CfgClipLeft:  cfg_d.clip_left   = cfg_data_i;
        cab_pkg::CfgClipTop:   cfg_d.clip_top    = cfg_data_i;
        cab_pkg::CfgClipRight: cfg_d.clip_right  = cfg_data_i;
        cab_pkg::CfgClipBot:   cfg_d.clip_bottom = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_red     <= 8'd0;
      cfg_q.src_green   <= 8'd0;
      cfg_q.src_blue    <= 8'd0;
      cfg_q.src_alpha   <= 8'd255;
      cfg_q.clip_left   <= 12'sd0;
      cfg_q.clip_top    <= 12'sd0;
      cfg_q.clip_right  <= 12'sd2047;
      cfg_q.clip_bottom <= 12'sd2047;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/cab_blend_pipe.sv
module cab_blend_pipe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cab_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [cab_pkg::CoordW-1:0] in_x_i,
  input  logic signed [cab_pkg::CoordW-1:0] in_y_i,
  input  logic [7:0]                        in_cov_i,
  input  logic [7:0]                        in_dest_i,
  input  logic                              in_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_we_o,
  output logic signed [cab_pkg::CoordW-1:0] out_x_o,
  output logic signed [cab_pkg::CoordW-1:0] out_y_o,
  output logic [7:0]                        out_pixel_o,
  output logic                              out_last_o
);

  typedef struct packed {
    logic signed [cab_pkg::CoordW-1:0] x;
    logic signed [cab_pkg::CoordW-1:0] y;
    logic [7:0]                        dest;
    logic                              last;
  } echo_t;

  typedef struct packed {
    echo_t       echo;
    logic        in_clip;
    logic [15:0] cov_alpha;
  } st1_t;

  typedef struct packed {
    echo_t                       echo;
    logic                        in_clip;
    logic [cab_pkg::ChanW-1:0]   alpha;
  } st2_t;

  typedef struct packed {
    echo_t       echo;
    logic        write;
    logic        full;
    logic [15:0] src_r;
    logic [15:0] src_g;
    logic [15:0] src_b;
    logic [15:0] dst_r;
    logic [15:0] dst_g;
    logic [15:0] dst_b;
  } st3_t;

  typedef struct packed {
    echo_t      echo;
    logic       write;
    logic [7:0] pixel;
  } st4_t;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  st1_t s1_q, s1_d;
  st2_t s2_q, s2_d;
  st3_t s3_q, s3_d;
  st4_t s4_q, s4_d;

  logic [cab_pkg::ChanW-1:0] inv_alpha;
  logic [7:0] dr, dg, db;
  logic [7:0] sum_r, sum_g, sum_b;

  // A stage takes new data when empty or when its content moves on
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: clip test and coverage times source alpha
  always_comb begin
    s1_d.echo.x    = in_x_i;
    s1_d.echo.y    = in_y_i;
    s1_d.echo.dest = in_dest_i;
    s1_d.echo.last = in_last_i;
    s1_d.in_clip   = (in_x_i >= cfg_i.clip_left) && (in_x_i < cfg_i.clip_right) &&
                     (in_y_i >= cfg_i.clip_top) && (in_y_i < cfg_i.clip_bottom);
    s1_d.cov_alpha = 16'(in_cov_i) * 16'(cfg_i.src_alpha);
  end

  // Stage 2: scale the product back to an 8-bit alpha
  always_comb begin
    s2_d.echo    = s1_q.echo;
    s2_d.in_clip = s1_q.in_clip;
    s2_d.alpha   = cab_pkg::div255(s1_q.cov_alpha);
  end

  // Stage 3: premultiply source and weight the expanded destination
  always_comb begin
    inv_alpha  = cab_pkg::AlphaFull - s2_q.alpha;
    dr         = {s2_q.echo.dest[7:5], 5'd0};
    dg         = {s2_q.echo.dest[4:2], 5'd0};
    db         = {s2_q.echo.dest[1:0], 6'd0};
    s3_d.echo  = s2_q.echo;
    s3_d.write = s2_q.in_clip && (s2_q.alpha != '0);
    s3_d.full  = s2_q.alpha == cab_pkg::AlphaFull;
    s3_d.src_r = 16'(cfg_i.src_red)   * 16'(s2_q.alpha);
    s3_d.src_g = 16'(cfg_i.src_green) * 16'(s2_q.alpha);
    s3_d.src_b = 16'(cfg_i.src_blue)  * 16'(s2_q.alpha);
    s3_d.dst_r = 16'(inv_alpha) * 16'(dr);
    s3_d.dst_g = 16'(inv_alpha) * 16'(dg);
    s3_d.dst_b = 16'(inv_alpha) * 16'(db);
  end

  // Stage 4: sum channels, pack and pick the pixel to write
  always_comb begin
    sum_r      = cab_pkg::div255(s3_q.src_r) + cab_pkg::div255(s3_q.dst_r);
    sum_g      = cab_pkg::div255(s3_q.src_g) + cab_pkg::div255(s3_q.dst_g);
    sum_b      = cab_pkg::div255(s3_q.src_b) + cab_pkg::div255(s3_q.dst_b);
    s4_d.echo  = s3_q.echo;
    s4_d.write = s3_q.write;
    if (!s3_q.write) begin
      s4_d.pixel = s3_q.echo.dest;
    end else if (s3_q.full) begin
      s4_d.pixel = cab_pkg::pack332(cfg_i.src_red, cfg_i.src_green, cfg_i.src_blue);
    end else begin
      s4_d.pixel = cab_pkg::pack332(sum_r, sum_g, sum_b);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Advance payload, hold on stall
  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
    if (rdy4) s4_q <= s4_d;
  end

  assign out_valid_o = v4_q;
  assign out_we_o    = s4_q.write;
  assign out_x_o     = s4_q.echo.x;
  assign out_y_o     = s4_q.echo.y;
  assign out_pixel_o = s4_q.pixel;
  assign out_last_o  = s4_q.echo.last;

endmodule

>>> rtl/coverage_alpha_blend_rgb332.sv
// Coverage alpha blend into an RGB332 frame buffer pixel, solid source color.
// Input stream (s_axis): one request per pixel with its coordinates, its
// coverage and the current frame buffer value; tlast marks the end of a span.
// Output stream (m_axis): one request per input pixel, in order, carrying the
// write flag in tuser, the echoed coordinates and the value to store; tlast
// echoes the span marker. Pixels outside the clip rectangle or with zero
// effective alpha come out with the write flag low and the old value.
// Configuration: cfg_we_i writes register cfg_idx_i (source red, green, blue,
// alpha, clip left, top, right, bottom) with cfg_data_i; write only while idle.
// A request accepted on s_axis passes four register stages (clip and alpha
// multiply, alpha scale, channel multiplies, channel sum and pack) and is offered
// on m_axis from the last; one pixel per cycle is sustained while m_axis_tready is high.
// Reset loads source 0,0,0 with alpha 255 and clip rectangle 0,0 to 2047,2047,
// and empties the pipeline. When the receiver stalls, the stages fill up and
// s_axis_tready falls once no stage is empty; no request is lost.
module coverage_alpha_blend_rgb332 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // pixel_x[11:0], pixel_y[23:12], coverage[31:24],
                                     // dest_pixel[39:32]
  input  logic        s_axis_tlast,  // span_last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_x[11:0], out_y[23:12], new_pixel[31:24]
  output logic        m_axis_tuser,  // write_enable
  output logic        m_axis_tlast   // span_done
);

  cab_pkg::cfg_t cfg;
  logic signed [cab_pkg::CoordW-1:0] out_x, out_y;
  logic [7:0] out_pixel;

  cab_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cab_blend_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_x_i      (s_axis_tdata[11:0]),
    .in_y_i      (s_axis_tdata[23:12]),
    .in_cov_i    (s_axis_tdata[31:24]),
    .in_dest_i   (s_axis_tdata[39:32]),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_we_o    (m_axis_tuser),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_pixel_o (out_pixel),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {out_pixel, out_y, out_x};

endmodule
